// ===== sv/pwc_pkg.sv =====
// Shared types, register indexes and helper functions for the Potts Wolff cluster block.
// Used by pwc_div, pwc_ctrl, pwc_dpath and potts_wolff_cluster_update.
package pwc_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_THRESH = 2'd0;
	localparam logic [1:0] REG_STATES = 2'd1;
	localparam logic [1:0] REG_SEED   = 2'd2;

	// lattice side; a power of two, so row and column are bit fields of the site index
	localparam int SIDE = 128;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int THR_W     = 16;
	localparam int NS_W      = 5;
	localparam int SITE_IN_W = 14;
	localparam int SHIFT_W   = 4;
	localparam int OUT_W     = 15;
	localparam int QX_W      = 9;

	localparam logic [31:0] DEFAULT_SEED = 32'd12345;
	localparam logic [OUT_W-1:0] OUT_MAX = 15'd32767;
	localparam logic [NS_W-1:0] NS_RESET = 5'd4;

	// restoring divider for the new spin modulo q
	localparam int DIV_NW = 14;
	localparam int DIV_DW = 10;
	localparam int DIV_CW = 4;

	// neighbor directions, in visiting order
	localparam logic [1:0] DIR_DOWN  = 2'd0;
	localparam logic [1:0] DIR_UP    = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	typedef struct packed {
		logic       latch_in;
		logic       div_go;
		logic       take_new;
		logic       spin_rd_start;
		logic       take_old;
		logic       cnt_rd_old;
		logic       cnt_rd_new;
		logic       take_cnt_old;
		logic       take_cnt_new;
		logic       seed_flip;
		logic       q_rd;
		logic       take_cur;
		logic       nb_rd;
		logic       nb_test;
		logic [1:0] dir;
		logic       wb_old;
		logic       wb_new;
		logic       sweep_clr;
		logic       sweep_rd;
		logic       sweep_acc;
		logic       finish;
		logic       clr_wr;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic div_done;
		logic q_empty;
		logic sweep_last;
		logic clr_last;
	} sts_t;

	function automatic logic [31:0] xorshift32(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

	function automatic logic [OUT_W-1:0] sat_out(input logic [31:0] v);
		return (v > 32'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
	endfunction

endpackage

// ===== sv/pwc_div.sv =====
// Restoring divider, one quotient bit per cycle; gives the remainder for the new spin.
// Depends on pwc_pkg for operand widths.
module pwc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [pwc_pkg::DIV_NW-1:0]  num,
	input  logic [pwc_pkg::DIV_DW-1:0]  den,
	output logic                        done,
	output logic [pwc_pkg::DIV_DW-1:0]  rem
);
	logic [pwc_pkg::DIV_DW-1:0] acc_q;
	logic [pwc_pkg::DIV_DW-1:0] den_q;
	logic [pwc_pkg::DIV_NW-1:0] quo_q;
	logic [pwc_pkg::DIV_CW-1:0] cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [pwc_pkg::DIV_DW:0]   trial;
	logic                       fits;

	assign trial = {acc_q, quo_q[pwc_pkg::DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pwc_pkg::DIV_CW'(pwc_pkg::DIV_NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			acc_q <= fits ? pwc_pkg::DIV_DW'(trial - {1'b0, den_q})
				: trial[pwc_pkg::DIV_DW-1:0];
			quo_q <= {quo_q[pwc_pkg::DIV_NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign rem  = acc_q;
endmodule

// ===== sv/pwc_ctrl.sv =====
// Sequencer for the cluster update: clear pass, setup, breadth-first growth, count sweep.
// Depends on pwc_pkg for the command and status structs.
module pwc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  pwc_pkg::sts_t  sts,
	output pwc_pkg::cmd_t  cmd,
	output logic           busy
);
	localparam logic [4:0] ST_CLEAR  = 5'd0;
	localparam logic [4:0] ST_IDLE   = 5'd1;
	localparam logic [4:0] ST_CHECK  = 5'd2;
	localparam logic [4:0] ST_SP_RD  = 5'd6;
	localparam logic [4:0] ST_SP_WT  = 5'd7;
	localparam logic [4:0] ST_D3_GO  = 5'd8;
	localparam logic [4:0] ST_D3_WT  = 5'd9;
	localparam logic [4:0] ST_C_OLD  = 5'd10;
	localparam logic [4:0] ST_C_NEW  = 5'd11;
	localparam logic [4:0] ST_C_TAKE = 5'd12;
	localparam logic [4:0] ST_SEED   = 5'd13;
	localparam logic [4:0] ST_POP    = 5'd14;
	localparam logic [4:0] ST_CUR    = 5'd15;
	localparam logic [4:0] ST_NB_RD  = 5'd16;
	localparam logic [4:0] ST_NB_TST = 5'd17;
	localparam logic [4:0] ST_WB_OLD = 5'd18;
	localparam logic [4:0] ST_WB_NEW = 5'd19;
	localparam logic [4:0] ST_SW_CLR = 5'd20;
	localparam logic [4:0] ST_SW_RD  = 5'd21;
	localparam logic [4:0] ST_SW_ACC = 5'd22;
	localparam logic [4:0] ST_DONE   = 5'd23;

	logic [4:0] state_q, state_d;
	logic [1:0] dir_q, dir_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		dir_d   = dir_q;
		cmd.dir = dir_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.latch_in = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.bad) begin
					state_d = ST_SW_CLR;
				end else begin
					state_d = ST_SP_RD;
				end
			end
			ST_SP_RD: begin
				cmd.spin_rd_start = 1'b1;
				state_d = ST_SP_WT;
			end
			ST_SP_WT: begin
				cmd.take_old = 1'b1;
				state_d = ST_D3_GO;
			end
			ST_D3_GO: begin
				cmd.div_go = 1'b1;
				state_d = ST_D3_WT;
			end
			ST_D3_WT: begin
				if (sts.div_done) begin
					cmd.take_new = 1'b1;
					state_d = ST_C_OLD;
				end
			end
			ST_C_OLD: begin
				cmd.cnt_rd_old = 1'b1;
				state_d = ST_C_NEW;
			end
			ST_C_NEW: begin
				cmd.cnt_rd_new   = 1'b1;
				cmd.take_cnt_old = 1'b1;
				state_d = ST_C_TAKE;
			end
			ST_C_TAKE: begin
				cmd.take_cnt_new = 1'b1;
				state_d = ST_SEED;
			end
			ST_SEED: begin
				cmd.seed_flip = 1'b1;
				state_d = ST_POP;
			end
			ST_POP: begin
				if (sts.q_empty) begin
					state_d = ST_WB_OLD;
				end else begin
					cmd.q_rd = 1'b1;
					state_d = ST_CUR;
				end
			end
			ST_CUR: begin
				cmd.take_cur = 1'b1;
				dir_d   = pwc_pkg::DIR_DOWN;
				state_d = ST_NB_RD;
			end
			ST_NB_RD: begin
				cmd.nb_rd = 1'b1;
				state_d = ST_NB_TST;
			end
			ST_NB_TST: begin
				cmd.nb_test = 1'b1;
				if (dir_q == pwc_pkg::DIR_LEFT) begin
					state_d = ST_POP;
				end else begin
					dir_d   = dir_q + 2'd1;
					state_d = ST_NB_RD;
				end
			end
			ST_WB_OLD: begin
				cmd.wb_old = 1'b1;
				state_d = ST_WB_NEW;
			end
			ST_WB_NEW: begin
				cmd.wb_new = 1'b1;
				state_d = ST_SW_CLR;
			end
			ST_SW_CLR: begin
				cmd.sweep_clr = 1'b1;
				state_d = ST_SW_RD;
			end
			ST_SW_RD: begin
				cmd.sweep_rd = 1'b1;
				state_d = ST_SW_ACC;
			end
			ST_SW_ACC: begin
				cmd.sweep_acc = 1'b1;
				state_d = sts.sweep_last ? ST_DONE : ST_SW_RD;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			dir_q   <= pwc_pkg::DIR_DOWN;
		end else begin
			state_q <= state_d;
			dir_q   <= dir_d;
		end
	end

	assign busy = state_q != ST_IDLE;
endmodule

// ===== sv/pwc_dpath.sv =====
// Datapath: registers, spin store, site queue, state counts, random source, divider.
// Depends on pwc_pkg and pwc_div.
module pwc_dpath #(
	parameter int MAX_STATES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pwc_pkg::cmd_t                   cmd,
	output pwc_pkg::sts_t                   sts,
	input  logic                            cfg_write,
	input  logic [pwc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pwc_pkg::CFG_W-1:0]       cfg_data,
	input  logic [pwc_pkg::SITE_IN_W-1:0]   start_site,
	input  logic [pwc_pkg::SHIFT_W-1:0]     spin_shift,
	output logic                            done,
	output logic [pwc_pkg::OUT_W-1:0]       flip_count,
	output logic [pwc_pkg::OUT_W-1:0]       largest_count,
	output logic                            bad_shift
);
	localparam int SIDE   = pwc_pkg::SIDE;
	localparam int NSITES = SIDE * SIDE;
	localparam int AW  = $clog2(NSITES);
	localparam int SCW = $clog2(NSITES + 1);
	localparam int RW  = $clog2(SIDE);
	localparam int SW  = $clog2(MAX_STATES);

	// configuration
	logic [pwc_pkg::THR_W-1:0] thr_q;
	logic [pwc_pkg::NS_W-1:0]  ns_q;
	logic [31:0]               rng_q;

	// item registers
	logic [pwc_pkg::SITE_IN_W-1:0] start_q;
	logic [pwc_pkg::SHIFT_W-1:0]   shift_q;
	logic [RW-1:0] cur_row_q, cur_col_q, nb_row_q, nb_col_q;
	logic [AW-1:0] nb_addr_q;
	logic [SW-1:0] old_q, new_q;
	logic [SCW-1:0] cnt_old_q, cnt_new_q, size_q, head_q, tail_q, best_q;
	logic [SW-1:0] swp_idx_q;
	logic [AW-1:0] clr_idx_q;

	// output registers
	logic                      done_q;
	logic [pwc_pkg::OUT_W-1:0] size_out_q, best_out_q;
	logic                      bad_out_q;

	// effective q and shift check
	logic [pwc_pkg::QX_W-1:0] qe;
	logic                     bad;
	always_comb begin
		if (ns_q < pwc_pkg::NS_W'(2))
			qe = pwc_pkg::QX_W'(2);
		else if (pwc_pkg::QX_W'(ns_q) > pwc_pkg::QX_W'(MAX_STATES))
			qe = pwc_pkg::QX_W'(MAX_STATES);
		else
			qe = pwc_pkg::QX_W'(ns_q);
	end
	assign bad = (shift_q == '0) || (pwc_pkg::QX_W'(shift_q) >= qe);

	// divider: new spin is (old + shift) mod q
	logic [pwc_pkg::DIV_NW-1:0] div_num;
	logic [pwc_pkg::DIV_DW-1:0] div_den, div_rem;
	logic                       div_done;
	assign div_num = pwc_pkg::DIV_NW'(old_q) + pwc_pkg::DIV_NW'(shift_q);
	assign div_den = pwc_pkg::DIV_DW'(qe);

	pwc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.rem    (div_rem)
	);

	// neighbor site, wrapped at the lattice edges
	logic [RW-1:0] nb_row, nb_col;
	always_comb begin
		nb_row = cur_row_q;
		nb_col = cur_col_q;
		case (cmd.dir)
			pwc_pkg::DIR_DOWN:
				nb_row = (cur_row_q == RW'(SIDE - 1)) ? '0 : cur_row_q + 1'b1;
			pwc_pkg::DIR_UP:
				nb_row = (cur_row_q == '0) ? RW'(SIDE - 1) : cur_row_q - 1'b1;
			pwc_pkg::DIR_RIGHT:
				nb_col = (cur_col_q == RW'(SIDE - 1)) ? '0 : cur_col_q + 1'b1;
			pwc_pkg::DIR_LEFT:
				nb_col = (cur_col_q == '0) ? RW'(SIDE - 1) : cur_col_q - 1'b1;
			default: begin
				nb_row = cur_row_q;
				nb_col = cur_col_q;
			end
		endcase
	end

	// start site wraps modulo the lattice size; row and column are its bit fields
	logic [AW-1:0] nb_addr, start_addr;
	assign nb_addr    = AW'(nb_row) * AW'(SIDE) + AW'(nb_col);
	assign start_addr = AW'(start_q);

	// spin store
	logic [SW-1:0] spin_mem [NSITES];
	logic [SW-1:0] spin_rd_q;
	logic          spin_we, spin_re;
	logic [AW-1:0] spin_waddr, spin_raddr;
	logic [SW-1:0] spin_wdata;
	logic          match, join_nb;
	logic [31:0]   rng_next;

	assign rng_next = pwc_pkg::xorshift32(rng_q);
	assign match    = spin_rd_q == old_q;
	assign join_nb  = cmd.nb_test && match && (rng_next[31:16] < thr_q)
		&& (tail_q < SCW'(NSITES));

	always_comb begin
		spin_we    = cmd.clr_wr || cmd.seed_flip || join_nb;
		spin_waddr = cmd.clr_wr ? clr_idx_q : (cmd.seed_flip ? start_addr : nb_addr_q);
		spin_wdata = cmd.clr_wr ? '0 : new_q;
		spin_re    = cmd.spin_rd_start || cmd.nb_rd;
		spin_raddr = cmd.spin_rd_start ? start_addr : nb_addr;
	end

	always_ff @(posedge clk) begin
		if (spin_we) spin_mem[spin_waddr] <= spin_wdata;
		if (spin_re) spin_rd_q <= spin_mem[spin_raddr];
	end

	// site queue, holds row and column of each joined site; the start site goes to slot 0
	logic [2*RW-1:0] que_mem [NSITES];
	logic [2*RW-1:0] que_rd_q;
	always_ff @(posedge clk) begin
		if (cmd.seed_flip)
			que_mem[AW'(0)] <= start_addr;
		else if (join_nb)
			que_mem[tail_q[AW-1:0]] <= {nb_row_q, nb_col_q};
		if (cmd.q_rd) que_rd_q <= que_mem[head_q[AW-1:0]];
	end

	// state counts; an entry never written reads as its reset value
	logic [SCW-1:0] cnt_mem [MAX_STATES];
	logic [MAX_STATES-1:0] cnt_vld_q;
	logic [SCW-1:0] cnt_rd_q;
	logic           cnt_rv_q, cnt_rz_q;
	logic [SW-1:0]  cnt_raddr, cnt_waddr;
	logic           cnt_re, cnt_we;
	logic [SCW-1:0] cnt_wdata, cnt_val;

	assign cnt_re    = cmd.cnt_rd_old || cmd.cnt_rd_new || cmd.sweep_rd;
	assign cnt_raddr = cmd.cnt_rd_old ? old_q : (cmd.cnt_rd_new ? new_q : swp_idx_q);
	assign cnt_we    = cmd.wb_old || cmd.wb_new;
	assign cnt_waddr = cmd.wb_old ? old_q : new_q;
	assign cnt_wdata = cmd.wb_old ? cnt_old_q : cnt_new_q;
	assign cnt_val   = cnt_rv_q ? cnt_rd_q : (cnt_rz_q ? SCW'(NSITES) : '0);

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
		if (cnt_re) begin
			cnt_rd_q <= cnt_mem[cnt_raddr];
			cnt_rv_q <= cnt_vld_q[cnt_raddr];
			cnt_rz_q <= cnt_raddr == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
		end else if (cnt_we) begin
			cnt_vld_q[cnt_waddr] <= 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= '0;
			ns_q      <= pwc_pkg::NS_RESET;
			rng_q     <= pwc_pkg::DEFAULT_SEED;
			clr_idx_q <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cfg_write) begin
				case (cfg_index)
					pwc_pkg::REG_THRESH: thr_q <= cfg_data[pwc_pkg::THR_W-1:0];
					pwc_pkg::REG_STATES: ns_q  <= cfg_data[pwc_pkg::NS_W-1:0];
					pwc_pkg::REG_SEED:
						rng_q <= (cfg_data != '0) ? cfg_data : pwc_pkg::DEFAULT_SEED;
					default: ;
				endcase
			end
			if (cmd.nb_test && match) rng_q <= rng_next;
			if (cmd.clr_wr) clr_idx_q <= clr_idx_q + 1'b1;
			if (cmd.seed_flip) begin
				head_q <= '0;
				tail_q <= SCW'(1);
			end
			if (join_nb) tail_q <= tail_q + 1'b1;
			if (cmd.q_rd) head_q <= head_q + 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			start_q <= start_site;
			shift_q <= spin_shift;
			size_q  <= '0;
		end
		if (cmd.take_old) old_q <= spin_rd_q;
		if (cmd.take_new) new_q <= SW'(div_rem);
		if (cmd.take_cnt_old) cnt_old_q <= cnt_val;
		if (cmd.take_cnt_new) cnt_new_q <= cnt_val;
		if (cmd.seed_flip || join_nb) begin
			cnt_old_q <= (cnt_old_q != '0) ? cnt_old_q - 1'b1 : '0;
			cnt_new_q <= cnt_new_q + 1'b1;
			size_q    <= size_q + 1'b1;
		end
		if (cmd.take_cur) {cur_row_q, cur_col_q} <= que_rd_q;
		if (cmd.nb_rd) begin
			nb_row_q  <= nb_row;
			nb_col_q  <= nb_col;
			nb_addr_q <= nb_addr;
		end
		if (cmd.sweep_clr) begin
			best_q    <= '0;
			swp_idx_q <= '0;
		end
		if (cmd.sweep_acc) begin
			if (cnt_val > best_q) best_q <= cnt_val;
			swp_idx_q <= swp_idx_q + 1'b1;
		end
		if (cmd.finish) begin
			size_out_q <= pwc_pkg::sat_out(32'(size_q));
			best_out_q <= pwc_pkg::sat_out(32'(best_q));
			bad_out_q  <= bad;
		end
	end

	assign sts.bad        = bad;
	assign sts.div_done   = div_done;
	assign sts.q_empty    = head_q == tail_q;
	assign sts.sweep_last = swp_idx_q == SW'(MAX_STATES - 1);
	assign sts.clr_last   = clr_idx_q == AW'(NSITES - 1);

	assign done          = done_q;
	assign flip_count    = size_out_q;
	assign largest_count = best_out_q;
	assign bad_shift     = bad_out_q;

	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");

	a_bad_no_size: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(bad_out_q && (size_out_q != '0)))
		else $error("rejected shift reported a nonzero cluster");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held two cycles");
endmodule

// ===== sv/potts_wolff_cluster_update.sv =====
// Top level of the Potts Wolff cluster update block.
// Depends on pwc_pkg, pwc_ctrl and pwc_dpath.
//
// Usage:
//   Configuration: write accept_threshold (index 0), num_states (index 1) or rng_seed
//   (index 2) with cfg_write/cfg_index/cfg_data while busy is low. A seed write
//   reloads the random generator at once; a zero seed loads the default seed.
//   Command: raise start with start_site and spin_shift; the word is taken at the
//   edge where start is high and busy is low. busy stays high until the result.
//   Result: done pulses for one cycle with flip_count, largest_count and
//   bad_shift. The receiver cannot hold the result off; latch it on done.
//   Sequence: a rejected shift goes from the check straight to the largest-count
//   sweep and the result. A valid one runs the check and the start-spin read, the
//   new spin on the 14-step divider, the count fetch and the start flip, then per
//   cluster site one queue pop plus four neighbor read/test pairs on the spin
//   store, then the empty-queue test, the count write-back, the largest-count
//   sweep and the result. One command at a time: busy is low again when done
//   rises, so the next word can be taken while done is high.
//   Reset: arst_n clears control state, then a clearing pass writes spin 0 to all
//   sites, one per cycle; busy is high for its length. Counts and the
//   generator return to their reset values.
module potts_wolff_cluster_update #(
	parameter int MAX_STATES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [pwc_pkg::SITE_IN_W-1:0]   start_site,
	input  logic [pwc_pkg::SHIFT_W-1:0]     spin_shift,
	output logic                            done,
	output logic [pwc_pkg::OUT_W-1:0]       flip_count,
	output logic [pwc_pkg::OUT_W-1:0]       largest_count,
	output logic                            bad_shift,
	input  logic                            cfg_write,
	input  logic [pwc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pwc_pkg::CFG_W-1:0]       cfg_data
);
	pwc_pkg::cmd_t cmd;
	pwc_pkg::sts_t sts;

	// sequencer: owns the state and the neighbor direction
	pwc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: stores, counters, random source and the divider
	pwc_dpath #(
		.MAX_STATES (MAX_STATES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start_site    (start_site),
		.spin_shift    (spin_shift),
		.done          (done),
		.flip_count    (flip_count),
		.largest_count (largest_count),
		.bad_shift     (bad_shift)
	);
endmodule
